/* hdl/sclhg_pkg.sv */
// shared types, codes and constants of the second core load hotplug governor
`default_nettype none

package sclhg_pkg;

  // default width of the idle and wall deltas
  localparam int unsigned DELTA_BITS_DEF = 32;

  // item and register geometry
  localparam int unsigned CMD_W       = 4;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned FREQ_W      = 22;
  localparam int unsigned LOAD_W      = 10;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 22;
  localparam int unsigned S_DATA_W    = 280;
  localparam int unsigned M_DATA_W    = 32;

  // percent scale, walked from the top bit down by the divider
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // register reset values
  localparam logic [LOAD_W-1:0]  LOAD_LOW_RST        = 10'd30;
  localparam logic [LOAD_W-1:0]  LOAD_HIGH_RST       = 10'd80;
  localparam logic [LOAD_W-1:0]  LOAD_LOW_SOFF_RST   = 10'd80;
  localparam logic [LOAD_W-1:0]  LOAD_HIGH_SOFF_RST  = 10'd1000;
  localparam logic [FREQ_W-1:0]  FREQ_SECOND_RST     = 22'd800000;
  localparam logic [DELAY_W-1:0] DELAY_NORMAL_RST    = 16'd100;
  localparam logic [DELAY_W-1:0] DELAY_AFTER_ON_RST  = 16'd200;
  localparam logic [DELAY_W-1:0] DELAY_SCREEN_OFF_RST = 16'd400;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 4'd0,
    CMD_SCREEN_OFF = 4'd1,
    CMD_SCREEN_ON  = 4'd2,
    CMD_SUSP_PREP  = 4'd3,
    CMD_POST_SUSP  = 4'd4,
    CMD_REBOOT     = 4'd5,
    CMD_MODE       = 4'd6,
    CMD_CORE       = 4'd7,
    CMD_LOCK       = 4'd8
  } sclhg_cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_DOWN = 2'd1,
    ACT_UP   = 2'd2
  } sclhg_act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOAD_LOW         = 3'd0,
    REG_LOAD_HIGH        = 3'd1,
    REG_LOAD_LOW_SOFF    = 3'd2,
    REG_LOAD_HIGH_SOFF   = 3'd3,
    REG_FREQ_SECOND      = 3'd4,
    REG_DELAY_NORMAL     = 3'd5,
    REG_DELAY_AFTER_ON   = 3'd6,
    REG_DELAY_SCREEN_OFF = 3'd7
  } sclhg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SAMPLE,
    ST_DIV,
    ST_DECIDE,
    ST_FINISH
  } sclhg_state_e;

  // result of the percent divider
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } sclhg_div_res_t;

endpackage

`default_nettype wire

/* hdl/second_core_load_hotplug_governor_unit.sv */
// top level of the second core load hotplug governor
`default_nettype none

// channel   | dir | handshake             | payload
// ----------+-----+-----------------------+-------------------------------------------
// s_axis    | in  | tvalid / tready       | tuser: command; tdata: value_on, times, freq
// m_axis    | out | tvalid / tready       | tdata: action, reschedule, delay, load, online
// cfg       | in  | cfg_we_i, no backpres | cfg_idx_i selects register, cfg_data_i value
//
// sequence: a non-tick command or a locked or manual tick runs ST_EXEC, then ST_FINISH;
//   an auto tick runs ST_EXEC, ST_SAMPLE and (nonzero wall delta) ST_DIV per online core,
//   then ST_DECIDE and ST_FINISH, or straight ST_FINISH when idle exceeds wall;
//   the next item is taken back in ST_IDLE; the shared percent divider takes 10 steps
//   per core: one doubling per bit of 100 and one add per set bit
// one item at a time: s_axis_tready_o is high only while the sequencer is idle
// a finished result waits in the output register; the block stalls in its last state
//   while that register is full and not taken
// reset: all control state and the configuration registers go to their documented reset values

module second_core_load_hotplug_governor_unit #(
  parameter int unsigned DELTA_BITS = sclhg_pkg::DELTA_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input items
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // low to high: value_on[0], idle_total_core0[64:1], wall_total_core0[128:65],
  // idle_total_core1[192:129], wall_total_core1[256:193], current_freq[278:257], zero
  input  wire logic [sclhg_pkg::S_DATA_W-1:0]        s_axis_tdata_i,
  // command[3:0]
  input  wire logic [sclhg_pkg::CMD_W-1:0]           s_axis_tuser_i,
  // result items
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // low to high: core1_action[1:0], reschedule[2], next_delay[18:3],
  // average_load[25:19], core1_online_now[26], zero
  output logic [sclhg_pkg::M_DATA_W-1:0]             m_axis_tdata_o,
  // register writes
  input  wire logic                                  cfg_we_i,
  input  wire logic [sclhg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [sclhg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import sclhg_pkg::*;

  // sequencer
  sclhg_state_e state_q, state_d;

  // configuration registers
  logic [LOAD_W-1:0]  load_low_q, load_high_q, load_low_soff_q, load_high_soff_q;
  logic [FREQ_W-1:0]  freq_second_q;
  logic [DELAY_W-1:0] delay_normal_q, delay_after_on_q, delay_soff_q;

  // governor state
  logic [TIME_W-1:0]  prev_idle_q [2];
  logic [TIME_W-1:0]  prev_wall_q [2];
  logic [TIME_W-1:0]  prev_idle_d [2];
  logic [TIME_W-1:0]  prev_wall_d [2];
  logic               core1_online_q, core1_online_d;
  logic               scr_dark_q, scr_dark_d;
  logic               lock_flag_q, lock_flag_d;
  logic               lock_saved_q, lock_saved_d;
  logic               auto_mode_q, auto_mode_d;
  logic               forced_on_q, forced_on_d;
  logic [DELAY_W-1:0] cur_delay_q, cur_delay_d;

  // captured item
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic               von_q, von_d;
  logic [TIME_W-1:0]  cap_idle_q [2];
  logic [TIME_W-1:0]  cap_wall_q [2];
  logic [TIME_W-1:0]  cap_idle_d [2];
  logic [TIME_W-1:0]  cap_wall_d [2];
  logic [FREQ_W-1:0]  freq_q, freq_d;

  // working result
  sclhg_act_e         action_q, action_d;
  logic               resched_q, resched_d;
  logic [PCT_W-1:0]   avg_q, avg_d;
  logic [PCT_W-1:0]   load0_q, load0_d, load1_q, load1_d;
  logic               core_sel_q, core_sel_d;

  // output register
  logic                m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;

  // sampling datapath
  logic [DELTA_BITS-1:0] d_idle, d_wall, d_busy;
  logic                  idle_over, wall_zero, more_cores, out_free;
  logic                  div_start;
  sclhg_div_res_t        div_res;

  // average and decision
  logic [PCT_W:0]     load_sum;
  logic [PCT_W-1:0]   avg_w;
  logic [LOAD_W-1:0]  thr_low, thr_high;
  logic               freq_low;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // deltas of the selected core, wrapped to the delta width
  assign d_idle     = cap_idle_q[core_sel_q][DELTA_BITS-1:0]
                    - prev_idle_q[core_sel_q][DELTA_BITS-1:0];
  assign d_wall     = cap_wall_q[core_sel_q][DELTA_BITS-1:0]
                    - prev_wall_q[core_sel_q][DELTA_BITS-1:0];
  assign d_busy     = d_wall - d_idle;
  assign idle_over  = (d_wall < d_idle);
  assign wall_zero  = (d_wall == '0);
  assign more_cores = !core_sel_q && core1_online_q;
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign div_start  = (state_q == ST_SAMPLE) && !idle_over && !wall_zero;

  assign load_sum = {1'b0, load0_q} + {1'b0, load1_q};
  assign avg_w    = core1_online_q ? load_sum[PCT_W:1] : load_sum[PCT_W-1:0];
  assign thr_low  = scr_dark_q ? load_low_soff_q : load_low_q;
  assign thr_high = scr_dark_q ? load_high_soff_q : load_high_q;
  assign freq_low = (freq_q < freq_second_q);

  sclhg_pct_div #(
    .DELTA_BITS (DELTA_BITS)
  ) u_pct_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .busy_i  (d_busy),
    .idle_i  (d_idle),
    .wall_i  (d_wall),
    .res_o   (div_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if ((cmd_q == CMD_TICK) && auto_mode_q && !lock_flag_q) state_d = ST_SAMPLE;
        else state_d = ST_FINISH;
      end
      ST_SAMPLE: begin
        priority if (idle_over) state_d = ST_FINISH;
        else if (!wall_zero)    state_d = ST_DIV;
        else if (more_cores)    state_d = ST_SAMPLE;
        else                    state_d = ST_DECIDE;
      end
      ST_DIV: begin
        if (div_res.done) state_d = more_cores ? ST_SAMPLE : ST_DECIDE;
      end
      ST_DECIDE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and governor state
  always_comb begin
    cmd_d          = cmd_q;
    von_d          = von_q;
    cap_idle_d     = cap_idle_q;
    cap_wall_d     = cap_wall_q;
    freq_d         = freq_q;
    prev_idle_d    = prev_idle_q;
    prev_wall_d    = prev_wall_q;
    core1_online_d = core1_online_q;
    scr_dark_d     = scr_dark_q;
    lock_flag_d    = lock_flag_q;
    lock_saved_d   = lock_saved_q;
    auto_mode_d    = auto_mode_q;
    forced_on_d    = forced_on_q;
    cur_delay_d    = cur_delay_q;
    action_d       = action_q;
    resched_d      = resched_q;
    avg_d          = avg_q;
    load0_d        = load0_q;
    load1_d        = load1_q;
    core_sel_d     = core_sel_q;
    m_valid_d      = m_valid_q && !m_axis_tready_i;
    m_data_d       = m_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d         = s_axis_tuser_i;
          von_d         = s_axis_tdata_i[0];
          cap_idle_d[0] = s_axis_tdata_i[64:1];
          cap_wall_d[0] = s_axis_tdata_i[128:65];
          cap_idle_d[1] = s_axis_tdata_i[192:129];
          cap_wall_d[1] = s_axis_tdata_i[256:193];
          freq_d        = s_axis_tdata_i[278:257];
          action_d      = ACT_NONE;
          resched_d     = 1'b0;
          avg_d         = '0;
          load0_d       = '0;
          load1_d       = '0;
          core_sel_d    = 1'b0;
        end
      end
      ST_EXEC: begin
        unique case (cmd_q)
          CMD_TICK: begin
            if (!auto_mode_q) begin
              // manual mode: only enforce a forced-off request
              if (!forced_on_q && core1_online_q) begin
                action_d       = ACT_DOWN;
                core1_online_d = 1'b0;
              end
            end else begin
              resched_d = 1'b1;
            end
          end
          CMD_SCREEN_OFF: begin
            scr_dark_d  = 1'b1;
            cur_delay_d = delay_soff_q;
          end
          CMD_SCREEN_ON: begin
            scr_dark_d  = 1'b0;
            cur_delay_d = delay_normal_q;
            resched_d   = 1'b1;
          end
          CMD_SUSP_PREP: begin
            lock_saved_d = lock_flag_q;
            lock_flag_d  = 1'b1;
          end
          CMD_POST_SUSP: lock_flag_d = lock_saved_q;
          CMD_REBOOT:    lock_flag_d = 1'b1;
          CMD_MODE: begin
            if (!lock_flag_q) begin
              if (von_q && !auto_mode_q) begin
                auto_mode_d = 1'b1;
                cur_delay_d = delay_normal_q;
                resched_d   = 1'b1;
              end else if (!von_q && auto_mode_q) begin
                auto_mode_d = 1'b0;
                forced_on_d = 1'b1;
                if (!core1_online_q) begin
                  action_d       = ACT_UP;
                  core1_online_d = 1'b1;
                end
              end
            end
          end
          CMD_CORE: begin
            if (!auto_mode_q && !lock_flag_q) begin
              if (von_q && !forced_on_q) begin
                forced_on_d = 1'b1;
                if (!core1_online_q) begin
                  action_d       = ACT_UP;
                  core1_online_d = 1'b1;
                end
              end else if (!von_q && forced_on_q) begin
                forced_on_d = 1'b0;
                if (core1_online_q) begin
                  action_d       = ACT_DOWN;
                  core1_online_d = 1'b0;
                end
              end
            end
          end
          CMD_LOCK: lock_flag_d = von_q;
          default: ;
        endcase
      end
      ST_SAMPLE: begin
        // prev values update even when the core is found inconsistent
        prev_idle_d[core_sel_q] = cap_idle_q[core_sel_q];
        prev_wall_d[core_sel_q] = cap_wall_q[core_sel_q];
        if (!idle_over && wall_zero && more_cores) core_sel_d = 1'b1;
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (core_sel_q) load1_d = div_res.pct;
          else            load0_d = div_res.pct;
          if (more_cores) core_sel_d = 1'b1;
        end
      end
      ST_DECIDE: begin
        avg_d = avg_w;
        if (((LOAD_W'(avg_w) < thr_low) || freq_low) && core1_online_q) begin
          action_d       = ACT_DOWN;
          core1_online_d = 1'b0;
          cur_delay_d    = scr_dark_q ? delay_soff_q : delay_normal_q;
        end else if ((LOAD_W'(avg_w) > thr_high) && !freq_low && !core1_online_q) begin
          action_d       = ACT_UP;
          core1_online_d = 1'b1;
          cur_delay_d    = delay_after_on_q;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0, core1_online_q, avg_q,
                       resched_q ? cur_delay_q : DELAY_W'(0),
                       resched_q, action_q};
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      prev_idle_q[0] <= '0;
      prev_idle_q[1] <= '0;
      prev_wall_q[0] <= '0;
      prev_wall_q[1] <= '0;
      core1_online_q <= 1'b1;
      scr_dark_q     <= 1'b0;
      lock_flag_q    <= 1'b0;
      lock_saved_q   <= 1'b0;
      auto_mode_q    <= 1'b1;
      forced_on_q    <= 1'b1;
      cur_delay_q    <= DELAY_NORMAL_RST;
      core_sel_q     <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      prev_idle_q    <= prev_idle_d;
      prev_wall_q    <= prev_wall_d;
      core1_online_q <= core1_online_d;
      scr_dark_q     <= scr_dark_d;
      lock_flag_q    <= lock_flag_d;
      lock_saved_q   <= lock_saved_d;
      auto_mode_q    <= auto_mode_d;
      forced_on_q    <= forced_on_d;
      cur_delay_q    <= cur_delay_d;
      core_sel_q     <= core_sel_d;
      m_valid_q      <= m_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_low_q       <= LOAD_LOW_RST;
      load_high_q      <= LOAD_HIGH_RST;
      load_low_soff_q  <= LOAD_LOW_SOFF_RST;
      load_high_soff_q <= LOAD_HIGH_SOFF_RST;
      freq_second_q    <= FREQ_SECOND_RST;
      delay_normal_q   <= DELAY_NORMAL_RST;
      delay_after_on_q <= DELAY_AFTER_ON_RST;
      delay_soff_q     <= DELAY_SCREEN_OFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOAD_LOW:         load_low_q       <= cfg_data_i[LOAD_W-1:0];
        REG_LOAD_HIGH:        load_high_q      <= cfg_data_i[LOAD_W-1:0];
        REG_LOAD_LOW_SOFF:    load_low_soff_q  <= cfg_data_i[LOAD_W-1:0];
        REG_LOAD_HIGH_SOFF:   load_high_soff_q <= cfg_data_i[LOAD_W-1:0];
        REG_FREQ_SECOND:      freq_second_q    <= cfg_data_i[FREQ_W-1:0];
        REG_DELAY_NORMAL:     delay_normal_q   <= cfg_data_i[DELAY_W-1:0];
        REG_DELAY_AFTER_ON:   delay_after_on_q <= cfg_data_i[DELAY_W-1:0];
        REG_DELAY_SCREEN_OFF: delay_soff_q     <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    von_q      <= von_d;
    cap_idle_q <= cap_idle_d;
    cap_wall_q <= cap_wall_d;
    freq_q     <= freq_d;
    action_q   <= action_d;
    resched_q  <= resched_d;
    avg_q      <= avg_d;
    load0_q    <= load0_d;
    load1_q    <= load1_d;
    m_data_q   <= m_data_d;
  end

endmodule

`default_nettype wire

/* hdl/sclhg_pct_div.sv */
// iterative percent divider: floor(100 * busy / wall), one compare and subtract a cycle
`default_nettype none

module sclhg_pct_div #(
  parameter int unsigned DELTA_BITS = sclhg_pkg::DELTA_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DELTA_BITS-1:0] busy_i,   // wall - idle
  input  wire logic [DELTA_BITS-1:0] idle_i,   // equals wall - busy
  input  wire logic [DELTA_BITS-1:0] wall_i,   // nonzero
  output sclhg_pkg::sclhg_div_res_t  res_o
);
  import sclhg_pkg::*;

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic                  phase_q, phase_d;   // 0 doubling step, 1 add step
  logic [2:0]            bit_q, bit_d;
  logic [PCT_W-1:0]      quo_q, quo_d;
  logic [DELTA_BITS-1:0] rem_q, rem_d;
  logic [DELTA_BITS-1:0] busy_q, busy_d;
  logic [DELTA_BITS-1:0] idle_q, idle_d;
  logic [DELTA_BITS-1:0] wall_q, wall_d;

  logic [DELTA_BITS+1:0] dbl;
  logic [DELTA_BITS+1:0] dbl_diff;
  logic                  last;

  always_comb begin
    dbl      = {1'b0, rem_q, 1'b0};
    dbl_diff = dbl - {2'b00, wall_q};
    last     = (bit_q == 3'd0) && (phase_q || !PCT_SCALE[0]);

    run_d   = run_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    bit_d   = bit_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    busy_d  = busy_q;
    idle_d  = idle_q;
    wall_d  = wall_q;

    if (run_q) begin
      if (!phase_q) begin
        // rem = 2 rem mod wall, shift a quotient bit in
        if (!dbl_diff[DELTA_BITS+1]) begin
          rem_d = dbl_diff[DELTA_BITS-1:0];
          quo_d = {quo_q[PCT_W-2:0], 1'b1};
        end else begin
          rem_d = dbl[DELTA_BITS-1:0];
          quo_d = {quo_q[PCT_W-2:0], 1'b0};
        end
      end else begin
        // rem = rem + busy mod wall
        if (rem_q >= idle_q) begin
          rem_d = rem_q - idle_q;
          quo_d = quo_q + 7'd1;
        end else begin
          rem_d = rem_q + busy_q;
        end
      end
      if (!phase_q && PCT_SCALE[bit_q]) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        bit_d   = bit_q - 3'd1;
      end
      if (last) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      run_d   = 1'b1;
      phase_d = 1'b0;
      bit_d   = 3'(PCT_W - 1);
      quo_d   = '0;
      rem_d   = '0;
      busy_d  = busy_i;
      idle_d  = idle_i;
      wall_d  = wall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      bit_q   <= '0;
    end else begin
      run_q   <= run_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    busy_q <= busy_d;
    idle_q <= idle_d;
    wall_q <= wall_d;
  end

  assign res_o.done = done_q;
  assign res_o.pct  = quo_q;

endmodule

`default_nettype wire
